// File: sv/block_io_fault_rule_matcher_top_defines.svh
// Assertion macros for the fault rule matcher.
`ifndef BLOCK_IO_FAULT_RULE_MATCHER_TOP_DEFINES_SVH
`define BLOCK_IO_FAULT_RULE_MATCHER_TOP_DEFINES_SVH

// Assert an implication on every clock edge outside reset.
`define BFRM_ASSERT_IMP(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Assert a next-cycle implication outside reset.
`define BFRM_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: sv/bfrm_pkg.sv
package bfrm_pkg;

    localparam int unsigned MaxRulesDef = 16;
    localparam logic [31:0] LfsrMask    = 32'h8020_0003;
    localparam logic [29:0] MaxDelayUs  = 30'd600_000_000;
    localparam logic [7:0]  OpInvalid   = 8'hFF;

    localparam logic [1:0] ReqLookup = 2'd0;
    localparam logic [1:0] ReqAdd    = 2'd1;
    localparam logic [1:0] ReqClear  = 2'd2;

    localparam logic [1:0] ActPass = 2'd0;
    localparam logic [1:0] ActFail = 2'd1;
    localparam logic [1:0] ActHold = 2'd2;

    localparam logic [1:0] AddOk      = 2'd0;
    localparam logic [1:0] AddInvalid = 2'd1;
    localparam logic [1:0] AddFull    = 2'd2;

    // Controller -> datapath commands.
    typedef struct packed {
        logic load_req;    // capture the input beat
        logic do_add;      // validate and append
        logic do_clear;    // empty the table
        logic scan_init;   // start scan at the newest entry
        logic rd_issue;    // read the current entry
        logic test;        // apply op/range test on the read entry
        logic div_start;   // start modulo of a fresh draw
        logic hit;         // take the tested entry
        logic step;        // move to the next older entry
        logic finish;      // build the lookup result
        logic out_load;    // load the output register
    } bfrm_cmd_t;

    // Datapath -> controller status.
    typedef struct packed {
        logic is_lookup;
        logic is_add;
        logic is_clear;
        logic scan_empty;  // no entry left to test
        logic match;       // op and range match
        logic need_draw;   // chance above 1
        logic div_busy;
        logic div_zero;    // remainder is zero
    } bfrm_sts_t;

endpackage

// File: sv/block_io_fault_rule_matcher_top.sv
// Add, remove-all and unused request types pass from decode straight to the output register;
// a lookup tests rules newest first, and a rule needing a draw waits on the restoring
// modulo unit; one item in flight at a time.
// The next beat can be taken in the cycle after the result beat is accepted.
// Reset: aresetn synchronous active low; empties the rule table, loads seed 1,
// clears the controller and output valid.
`include "block_io_fault_rule_matcher_top_defines.svh"
module block_io_fault_rule_matcher_top
    import bfrm_pkg::*;
#(
    parameter int unsigned MAX_RULES = MaxRulesDef
) (
    input  logic        aclk,
    input  logic        aresetn,
    // Seed register write
    input  logic        cfg_we,
    input  logic [31:0] cfg_wdata,
    // Request channel
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_req_type,
    input  logic [7:0]  s_op_code,
    input  logic [63:0] s_start_sector,
    input  logic [63:0] s_sector_count,
    input  logic [7:0]  s_status_code,
    input  logic [31:0] s_chance,
    input  logic [29:0] s_delay_us,
    input  logic        s_no_wait,
    // Result channel
    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_action,
    output logic [7:0]  m_status_out,
    output logic [29:0] m_delay_out,
    output logic [1:0]  m_add_result
);
    bfrm_cmd_t cmd;
    bfrm_sts_t sts;

    // Controller: sequence the scan, newest rule first.
    bfrm_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    // Datapath: rule memory, LFSR, modulo unit, result register.
    bfrm_datapath #(.MAX_RULES(MAX_RULES)) u_dp (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cmd            (cmd),
        .sts            (sts),
        .cfg_we         (cfg_we),
        .cfg_wdata      (cfg_wdata),
        .s_req_type     (s_req_type),
        .s_op_code      (s_op_code),
        .s_start_sector (s_start_sector),
        .s_sector_count (s_sector_count),
        .s_status_code  (s_status_code),
        .s_chance       (s_chance),
        .s_delay_us     (s_delay_us),
        .s_no_wait      (s_no_wait),
        .m_action       (m_action),
        .m_status_out   (m_status_out),
        .m_delay_out    (m_delay_out),
        .m_add_result   (m_add_result)
    );

    // A held result beat must be dropped only on handshake.
    `BFRM_ASSERT_NEXT(a_mvalid_hold, aclk, aresetn, m_valid && !m_ready, m_valid, "beat dropped")
    // No new beat while a result is pending.
    `BFRM_ASSERT_IMP(a_no_overlap, aclk, aresetn, m_valid, !s_ready, "accept while pending")
    // A hold action always carries a nonzero delay.
    `BFRM_ASSERT_IMP(a_hold_delay, aclk, aresetn, m_valid && m_action == ActHold, m_delay_out != 30'd0, "no delay")
endmodule

// File: sv/bfrm_mod.sv
// Restoring modulo unit: one quotient bit per cycle.
module bfrm_mod
    import bfrm_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        start,
    input  logic [31:0] dividend,
    input  logic [31:0] divisor,
    output logic        busy,
    output logic        rem_zero
);
    logic [31:0] dvd_reg, dvd_next;
    logic [32:0] rem_reg, rem_next;
    logic [31:0] dsr_reg, dsr_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic [32:0] shifted;
    logic [32:0] diff;

    always_comb begin
        dvd_next = dvd_reg;
        rem_next = rem_reg;
        dsr_next = dsr_reg;
        cnt_next = cnt_reg;
        shifted  = {rem_reg[31:0], dvd_reg[31]};
        diff     = shifted - {1'b0, dsr_reg};
        if (start) begin
            dvd_next = dividend;
            dsr_next = divisor;
            rem_next = '0;
            cnt_next = 6'd32;
        end else if (cnt_reg != 6'd0) begin
            dvd_next = {dvd_reg[30:0], 1'b0};
            rem_next = diff[32] ? shifted : diff;
            cnt_next = cnt_reg - 6'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else begin
            cnt_reg <= cnt_next;
        end
        dvd_reg <= dvd_next;
        rem_reg <= rem_next;
        dsr_reg <= dsr_next;
    end

    assign busy     = (cnt_reg != 6'd0);
    assign rem_zero = (rem_reg == 33'd0);
endmodule

// File: sv/bfrm_datapath.sv
module bfrm_datapath
    import bfrm_pkg::*;
#(
    parameter int unsigned MAX_RULES = MaxRulesDef
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  bfrm_cmd_t   cmd,
    output bfrm_sts_t   sts,
    input  logic        cfg_we,
    input  logic [31:0] cfg_wdata,
    input  logic [1:0]  s_req_type,
    input  logic [7:0]  s_op_code,
    input  logic [63:0] s_start_sector,
    input  logic [63:0] s_sector_count,
    input  logic [7:0]  s_status_code,
    input  logic [31:0] s_chance,
    input  logic [29:0] s_delay_us,
    input  logic        s_no_wait,
    output logic [1:0]  m_action,
    output logic [7:0]  m_status_out,
    output logic [29:0] m_delay_out,
    output logic [1:0]  m_add_result
);
    localparam int unsigned IdxW = (MAX_RULES > 1) ? $clog2(MAX_RULES) : 1;
    localparam int unsigned CntW = $clog2(MAX_RULES + 1);
    localparam logic [CntW-1:0] FullCnt = CntW'(MAX_RULES);

    // Rule memory: one write port, one registered read port.
    logic [63:0] mem_first [MAX_RULES];
    logic [63:0] mem_last  [MAX_RULES];
    logic [7:0]  mem_op    [MAX_RULES];
    logic [7:0]  mem_stat  [MAX_RULES];
    logic [31:0] mem_odds  [MAX_RULES];
    logic [29:0] mem_hold  [MAX_RULES];

    logic [63:0] rd_first_reg, rd_last_reg;
    logic [7:0]  rd_op_reg, rd_stat_reg;
    logic [31:0] rd_odds_reg;
    logic [29:0] rd_hold_reg;

    logic [1:0]  req_reg;
    logic [7:0]  op_reg, stat_reg;
    logic [63:0] start_reg, count_reg, end_reg;
    logic [31:0] chance_reg;
    logic [29:0] delay_reg;
    logic        nowait_reg;

    logic [CntW-1:0] count_rules_reg;
    logic [CntW-1:0] scan_reg;
    logic [31:0]     lfsr_reg, lfsr_next;
    logic            match_reg;
    logic [7:0]      hit_stat_reg;
    logic [29:0]     hit_hold_reg;

    logic [1:0]  act_reg;
    logic [7:0]  sout_reg;
    logic [29:0] dout_reg;
    logic [1:0]  ares_reg;

    logic [64:0] end_sum;
    logic [63:0] add_last;
    logic        add_ovf;
    logic [1:0]  add_code;
    logic [IdxW-1:0] wr_idx, rd_idx;
    logic [CntW-1:0] scan_dec;

    assign end_sum  = {1'b0, s_start_sector} + {1'b0, s_sector_count};
    assign add_ovf  = (count_reg != 64'd0) && (~count_reg < start_reg);
    assign add_last = (count_reg == 64'd0) ? '1 : start_reg + count_reg - 64'd1;
    assign wr_idx   = count_rules_reg[IdxW-1:0];
    assign scan_dec = scan_reg - CntW'(1);
    assign rd_idx   = scan_dec[IdxW-1:0];

    always_comb begin
        priority if (op_reg == OpInvalid) add_code = AddInvalid;
        else if (stat_reg == 8'd0 && delay_reg == 30'd0) add_code = AddInvalid;
        else if (delay_reg > MaxDelayUs) add_code = AddInvalid;
        else if (add_ovf) add_code = AddInvalid;
        else if (count_rules_reg >= FullCnt) add_code = AddFull;
        else add_code = AddOk;
    end

    always_comb begin
        lfsr_next = {1'b0, lfsr_reg[31:1]} ^ (lfsr_reg[0] ? LfsrMask : 32'd0);
    end

    always_ff @(posedge aclk) begin
        if (cmd.do_add && add_code == AddOk) begin
            mem_first[wr_idx] <= start_reg;
            mem_last[wr_idx]  <= add_last;
            mem_op[wr_idx]    <= op_reg;
            mem_stat[wr_idx]  <= stat_reg;
            mem_odds[wr_idx]  <= chance_reg;
            mem_hold[wr_idx]  <= delay_reg;
        end
        if (cmd.rd_issue) begin
            rd_first_reg <= mem_first[rd_idx];
            rd_last_reg  <= mem_last[rd_idx];
            rd_op_reg    <= mem_op[rd_idx];
            rd_stat_reg  <= mem_stat[rd_idx];
            rd_odds_reg  <= mem_odds[rd_idx];
            rd_hold_reg  <= mem_hold[rd_idx];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_rules_reg <= '0;
            lfsr_reg        <= 32'd1;
            scan_reg        <= '0;
            match_reg       <= 1'b0;
        end else begin
            if (cfg_we) begin
                lfsr_reg <= (cfg_wdata == 32'd0) ? 32'd1 : cfg_wdata;
            end else if (cmd.div_start) begin
                lfsr_reg <= lfsr_next;
            end
            if (cmd.do_add && add_code == AddOk) begin
                count_rules_reg <= count_rules_reg + CntW'(1);
            end else if (cmd.do_clear) begin
                count_rules_reg <= '0;
            end
            if (cmd.scan_init) begin
                scan_reg <= count_rules_reg;
            end else if (cmd.step) begin
                scan_reg <= scan_dec;
            end
            if (cmd.test) begin
                match_reg <= (rd_op_reg == op_reg) && (start_reg <= rd_last_reg)
                             && (end_reg > rd_first_reg);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_req) begin
            req_reg    <= s_req_type;
            op_reg     <= s_op_code;
            start_reg  <= s_start_sector;
            count_reg  <= s_sector_count;
            end_reg    <= end_sum[64] ? '1 : end_sum[63:0];
            stat_reg   <= s_status_code;
            chance_reg <= s_chance;
            delay_reg  <= s_delay_us;
            nowait_reg <= s_no_wait;
        end
        if (cmd.scan_init) begin
            hit_stat_reg <= '0;
            hit_hold_reg <= '0;
        end else if (cmd.hit) begin
            hit_stat_reg <= rd_stat_reg;
            hit_hold_reg <= rd_hold_reg;
        end
        if (cmd.out_load) begin
            act_reg  <= ActPass;
            sout_reg <= '0;
            dout_reg <= '0;
            ares_reg <= AddOk;
            if (cmd.do_add) begin
                ares_reg <= add_code;
            end else if (cmd.finish) begin
                if (hit_hold_reg != 30'd0 && !nowait_reg) begin
                    act_reg  <= ActHold;
                    sout_reg <= hit_stat_reg;
                    dout_reg <= hit_hold_reg;
                end else if (hit_stat_reg != 8'd0) begin
                    act_reg  <= ActFail;
                    sout_reg <= hit_stat_reg;
                end
            end
        end
    end

    bfrm_mod u_mod (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (cmd.div_start),
        .dividend (lfsr_next),
        .divisor  (rd_odds_reg),
        .busy     (sts.div_busy),
        .rem_zero (sts.div_zero)
    );

    assign sts.is_lookup  = (req_reg == ReqLookup);
    assign sts.is_add     = (req_reg == ReqAdd);
    assign sts.is_clear   = (req_reg == ReqClear);
    assign sts.scan_empty = (scan_reg == '0);
    assign sts.match      = match_reg;
    assign sts.need_draw  = (rd_odds_reg > 32'd1);

    assign m_action     = act_reg;
    assign m_status_out = sout_reg;
    assign m_delay_out  = dout_reg;
    assign m_add_result = ares_reg;
endmodule

// File: sv/bfrm_ctrl.sv
module bfrm_ctrl
    import bfrm_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    output logic      m_valid,
    input  logic      m_ready,
    input  bfrm_sts_t sts,
    output bfrm_cmd_t cmd
);
    typedef enum logic [7:0] {
        ST_IDLE  = 8'b0000_0001,
        ST_DECODE = 8'b0000_0010,
        ST_READ  = 8'b0000_0100,
        ST_TEST  = 8'b0000_1000,
        ST_JUDGE = 8'b0001_0000,
        ST_DIV   = 8'b0010_0000,
        ST_WAITD = 8'b0100_0000,
        ST_OUT   = 8'b1000_0000
    } state_t;

    state_t state_reg, state_next;
    logic   mvalid_reg, mvalid_next;

    // A new beat is taken only when the output register is free.
    assign s_ready = (state_reg == ST_IDLE) && !mvalid_reg;
    assign m_valid = mvalid_reg;

    always_comb begin
        state_next  = state_reg;
        mvalid_next = mvalid_reg;
        cmd         = '0;
        if (mvalid_reg && m_ready) mvalid_next = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid && s_ready) begin
                    cmd.load_req = 1'b1;
                    state_next   = ST_DECODE;
                end
            end
            ST_DECODE: begin
                cmd.scan_init = 1'b1;
                if (sts.is_lookup) begin
                    state_next = ST_READ;
                end else begin
                    cmd.do_add   = sts.is_add;
                    cmd.do_clear = sts.is_clear;
                    cmd.out_load = 1'b1;
                    state_next   = ST_OUT;
                end
            end
            ST_READ: begin
                if (sts.scan_empty) begin
                    cmd.finish   = 1'b1;
                    cmd.out_load = 1'b1;
                    state_next   = ST_OUT;
                end else begin
                    cmd.rd_issue = 1'b1;
                    state_next   = ST_TEST;
                end
            end
            ST_TEST: begin
                cmd.test   = 1'b1;
                state_next = ST_JUDGE;
            end
            ST_JUDGE: begin
                if (!sts.match) begin
                    cmd.step   = 1'b1;
                    state_next = ST_READ;
                end else if (sts.need_draw) begin
                    cmd.div_start = 1'b1;
                    state_next    = ST_DIV;
                end else begin
                    cmd.hit      = 1'b1;
                    state_next   = ST_WAITD;
                end
            end
            ST_DIV: begin
                if (!sts.div_busy) begin
                    if (sts.div_zero) begin
                        cmd.hit    = 1'b1;
                        state_next = ST_WAITD;
                    end else begin
                        cmd.step   = 1'b1;
                        state_next = ST_READ;
                    end
                end
            end
            ST_WAITD: begin
                cmd.finish   = 1'b1;
                cmd.out_load = 1'b1;
                state_next   = ST_OUT;
            end
            ST_OUT: begin
                mvalid_next = 1'b1;
                state_next  = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_IDLE;
            mvalid_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            mvalid_reg <= mvalid_next;
        end
    end
endmodule

// File: test/tb_block_io_fault_rule_matcher_top.sv
`timescale 1ns / 100ps
module tb_block_io_fault_rule_matcher_top
    import bfrm_pkg::*;
;

    localparam int NumRandom  = 1650;
    localparam int CycleLimit = 5000000;
    localparam int TableDepth = 16;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_we = 1'b0;
    logic [31:0] cfg_wdata = '0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [1:0]  s_req_type = '0;
    logic [7:0]  s_op_code = '0;
    logic [63:0] s_start_sector = '0;
    logic [63:0] s_sector_count = '0;
    logic [7:0]  s_status_code = '0;
    logic [31:0] s_chance = '0;
    logic [29:0] s_delay_us = '0;
    logic        s_no_wait = 1'b0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [1:0]  m_action;
    logic [7:0]  m_status_out;
    logic [29:0] m_delay_out;
    logic [1:0]  m_add_result;

    typedef struct packed {
        logic [1:0]  req;
        logic [7:0]  op;
        logic [63:0] start;
        logic [63:0] count;
        logic [7:0]  status;
        logic [31:0] chance;
        logic [29:0] delay;
        logic        no_wait;
    } request_t;

    typedef struct packed {
        logic [1:0]  action;
        logic [7:0]  status;
        logic [29:0] delay;
        logic [1:0]  add_res;
    } verdict_t;

    // One directed row: the request, and an expected verdict where it is obvious.
    typedef struct {
        request_t req;
        bit       typed;
        verdict_t want;
    } vector_t;

    block_io_fault_rule_matcher_top uut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .s_valid(s_valid), .s_ready(s_ready),
        .s_req_type(s_req_type), .s_op_code(s_op_code),
        .s_start_sector(s_start_sector), .s_sector_count(s_sector_count),
        .s_status_code(s_status_code), .s_chance(s_chance),
        .s_delay_us(s_delay_us), .s_no_wait(s_no_wait),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_action(m_action), .m_status_out(m_status_out),
        .m_delay_out(m_delay_out), .m_add_result(m_add_result)
    );

    always #1 aclk = ~aclk;

    // Shadow of the rule table and the chance generator.
    logic [63:0] tbl_first [TableDepth];
    logic [63:0] tbl_last  [TableDepth];
    logic [7:0]  tbl_op    [TableDepth];
    logic [7:0]  tbl_status[TableDepth];
    logic [31:0] tbl_odds  [TableDepth];
    logic [29:0] tbl_hold  [TableDepth];
    int          tbl_used;
    logic [31:0] lfsr;

    verdict_t pending_verdicts[$];
    int       errors = 0;
    int       cycles = 0;
    bit       idle_free = 1'b0;   // long stretch with no idling on either side

    function automatic logic [31:0] next_draw();
        logic bit0;
        bit0 = lfsr[0];
        lfsr = lfsr >> 1;
        if (bit0) lfsr = lfsr ^ LfsrMask;
        return lfsr;
    endfunction

    function automatic logic [1:0] insert_rule(request_t r);
        logic [63:0] last;
        if (r.op == OpInvalid) return AddInvalid;
        if (r.status == 0 && r.delay == 0) return AddInvalid;
        if (r.delay > MaxDelayUs) return AddInvalid;
        if (r.count != 0) begin
            if (64'hFFFF_FFFF_FFFF_FFFF - r.count < r.start) return AddInvalid;
            last = r.start + r.count - 64'd1;
        end else begin
            last = '1;
        end
        if (tbl_used >= TableDepth) return AddFull;
        tbl_first[tbl_used]  = r.start;
        tbl_last[tbl_used]   = last;
        tbl_op[tbl_used]     = r.op;
        tbl_status[tbl_used] = r.status;
        tbl_odds[tbl_used]   = r.chance;
        tbl_hold[tbl_used]   = r.delay;
        tbl_used++;
        return AddOk;
    endfunction

    function automatic verdict_t match_request(request_t r);
        verdict_t v;
        logic [63:0] stop;
        logic [7:0]  st;
        logic [29:0] hd;
        v = '0;
        st = '0;
        hd = '0;
        if (r.req == ReqLookup) begin
            stop = (64'hFFFF_FFFF_FFFF_FFFF - r.count < r.start) ? '1 : r.start + r.count;
            // Scan newest first; stop at the first rule that fires.
            for (int i = tbl_used - 1; i >= 0; i--) begin
                if (tbl_op[i] != r.op) continue;
                if (r.start > tbl_last[i] || stop <= tbl_first[i]) continue;
                if (tbl_odds[i] > 1 && (next_draw() % tbl_odds[i]) != 0) continue;
                st = tbl_status[i];
                hd = tbl_hold[i];
                break;
            end
            if (hd != 0 && !r.no_wait) begin
                v.action = ActHold;
                v.status = st;
                v.delay  = hd;
            end else if (st != 0) begin
                v.action = ActFail;
                v.status = st;
            end
        end else if (r.req == ReqAdd) begin
            v.add_res = insert_rule(r);
        end else if (r.req == ReqClear) begin
            tbl_used = 0;
        end
        return v;
    endfunction

    // Write the seed; only called with the block idle.
    task automatic load_seed(logic [31:0] seed);
        @(negedge aclk);
        cfg_we    <= 1'b1;
        cfg_wdata <= seed;
        @(negedge aclk);
        cfg_we    <= 1'b0;
        lfsr = (seed == 0) ? 32'd1 : seed;
    endtask

    // Drop valid, hold the sender until every verdict is back, then let the block settle.
    task automatic drain();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (pending_verdicts.size() != 0) @(negedge aclk);
        repeat (4) @(negedge aclk);
    endtask

    // Present one beat at a falling edge, after random idling outside the quiet stretch, hold until accepted.
    task automatic send_beat(request_t r);
        @(negedge aclk);
        while (!idle_free && $urandom_range(99) < 29) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid        <= 1'b1;
        s_req_type     <= r.req;
        s_op_code      <= r.op;
        s_start_sector <= r.start;
        s_sector_count <= r.count;
        s_status_code  <= r.status;
        s_chance       <= r.chance;
        s_delay_us     <= r.delay;
        s_no_wait      <= r.no_wait;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        pending_verdicts.push_back(match_request(r));
    endtask

    function automatic logic [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    // Keep sector values clustered so that lookups overlap rules often.
    function automatic logic [63:0] pick_sector();
        case ($urandom_range(5))
            0: return rand64();
            1: return 64'hFFFF_FFFF_FFFF_FFFF - 64'($urandom_range(300));
            default: return 64'($urandom_range(400));
        endcase
    endfunction

    function automatic request_t random_request();
        request_t r;
        int sel;
        r = '0;
        sel = $urandom_range(99);
        r.op      = ($urandom_range(19) == 0) ? 8'($urandom()) : 8'($urandom_range(3));
        r.start   = pick_sector();
        r.count   = ($urandom_range(7) == 0) ? rand64()
                  : ($urandom_range(9) == 0) ? 64'd0 : 64'($urandom_range(200));
        r.no_wait = 1'($urandom_range(1));
        if (sel < 60) begin
            r.req = ReqLookup;
        end else if (sel < 94) begin
            r.req = ReqAdd;
            r.status = ($urandom_range(2) == 0) ? 8'd0 : 8'($urandom());
            r.delay  = ($urandom_range(2) == 0) ? 30'd0
                     : ($urandom_range(9) == 0) ? 30'($urandom()) : 30'($urandom_range(5000));
            r.chance = ($urandom_range(15) == 0) ? $urandom() : 32'($urandom_range(4));
        end else if (sel < 98) begin
            r.req = ReqClear;
        end else begin
            r.req = 2'd3;
            r.status = 8'($urandom());
            r.chance = $urandom();
            r.delay  = 30'($urandom());
        end
        return r;
    endfunction

    // Check every result beat against the oldest expectation.
    always @(posedge aclk) begin
        verdict_t want;
        cycles <= cycles + 1;
        if (aresetn && m_valid && m_ready) begin
            if (pending_verdicts.size() == 0) begin
                $error("result beat with nothing expected");
                errors++;
            end else begin
                want = pending_verdicts.pop_front();
                if (m_action !== want.action) begin
                    $error("action: expected %0d actual %0d", want.action, m_action);
                    errors++;
                end
                if (m_status_out !== want.status) begin
                    $error("status_out: expected %0d actual %0d", want.status, m_status_out);
                    errors++;
                end
                if (m_delay_out !== want.delay) begin
                    $error("delay_out: expected %0d actual %0d", want.delay, m_delay_out);
                    errors++;
                end
                if (m_add_result !== want.add_res) begin
                    $error("add_result: expected %0d actual %0d", want.add_res, m_add_result);
                    errors++;
                end
            end
        end
    end

    // Receiver stalls at random, except during the quiet stretch.
    always @(negedge aclk) begin
        m_ready <= idle_free ? 1'b1 : ($urandom_range(99) >= 29);
    end

    // Watchdog.
    always @(posedge aclk) begin
        if (cycles > CycleLimit) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    vector_t directed[$];

    task automatic add_row(request_t r, bit typed, verdict_t want);
        vector_t row;
        row.req = r;
        row.typed = typed;
        row.want = want;
        directed.push_back(row);
    endtask

    initial begin
        request_t r;
        verdict_t got;
        verdict_t none;
        none = '0;
        tbl_used = 0;
        lfsr = 32'd1;

        // Hold reset, then release it on a falling edge.
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Directed rows. Empty table lookup passes.
        r = '0; r.req = ReqLookup; r.start = '1; r.count = '1;
        add_row(r, 1, none);
        // Invalid op, no status and no delay, delay too long, range overflow.
        r = '0; r.req = ReqAdd; r.op = OpInvalid; r.status = 8'd5;
        add_row(r, 1, verdict_t'{ActPass, 8'd0, 30'd0, AddInvalid});
        r = '0; r.req = ReqAdd; r.op = 8'd1;
        add_row(r, 1, verdict_t'{ActPass, 8'd0, 30'd0, AddInvalid});
        r = '0; r.req = ReqAdd; r.op = 8'd1; r.status = 8'd1; r.delay = '1;
        add_row(r, 1, verdict_t'{ActPass, 8'd0, 30'd0, AddInvalid});
        r = '0; r.req = ReqAdd; r.op = 8'd1; r.status = 8'd1;
        r.start = '1; r.count = 64'd2;
        add_row(r, 1, verdict_t'{ActPass, 8'd0, 30'd0, AddInvalid});
        // Largest legal delay, count zero to end of disk.
        r = '0; r.req = ReqAdd; r.op = 8'd2; r.status = 8'hFF; r.delay = MaxDelayUs;
        r.start = 64'd100;
        add_row(r, 1, none);
        // Held lookup, then the same one with no wait, then a zero-length miss.
        r = '0; r.req = ReqLookup; r.op = 8'd2; r.start = '1; r.count = '1;
        add_row(r, 1, verdict_t'{ActHold, 8'hFF, MaxDelayUs, AddOk});
        r.no_wait = 1'b1;
        add_row(r, 1, verdict_t'{ActFail, 8'hFF, 30'd0, AddOk});
        r = '0; r.req = ReqLookup; r.op = 8'd2; r.start = 64'd100;
        add_row(r, 1, none);
        // Delay with success status, held vs no wait.
        r = '0; r.req = ReqAdd; r.op = 8'd0; r.delay = 30'd7; r.count = 64'd1;
        add_row(r, 1, none);
        r = '0; r.req = ReqLookup; r.op = 8'd0; r.count = 64'd1; r.no_wait = 1'b1;
        add_row(r, 1, none);
        r.no_wait = 1'b0;
        add_row(r, 1, verdict_t'{ActHold, 8'd0, 30'd7, AddOk});
        // Chance rules use the generator.
        r = '0; r.req = ReqAdd; r.op = 8'd3; r.status = 8'd9; r.chance = '1;
        add_row(r, 0, none);
        r = '0; r.req = ReqAdd; r.op = 8'd3; r.status = 8'd4; r.chance = 32'd3;
        r.start = 64'd50; r.count = 64'd10;
        add_row(r, 0, none);
        for (int k = 0; k < 4; k++) begin
            r = '0; r.req = ReqLookup; r.op = 8'd3; r.start = 64'd55; r.count = 64'd2;
            add_row(r, 0, none);
        end
        // Unused request type with all bits set, then clear the table.
        r = '1; r.req = 2'd3;
        add_row(r, 1, none);
        r = '0; r.req = ReqClear;
        add_row(r, 1, none);

        foreach (directed[n]) begin
            got = match_request(directed[n].req);
            // Replay through the shadow was done above; undo by reusing send path.
            directed[n].want = directed[n].typed ? directed[n].want : got;
        end
        // Rebuild shadow from reset before sending.
        tbl_used = 0;
        lfsr = 32'd1;
        foreach (directed[n]) begin
            send_beat(directed[n].req);
            if (pending_verdicts[$] !== directed[n].want) begin
                $error("directed row %0d: table entry disagrees with prediction", n);
                errors++;
            end
        end
        drain();

        // Fill beyond capacity to reach the table-full answer.
        for (int k = 0; k < TableDepth + 2; k++) begin
            r = '0; r.req = ReqAdd; r.op = 8'd1; r.status = 8'(k + 1);
            r.start = 64'(k * 10); r.count = 64'd10; r.chance = 32'd2;
            send_beat(r);
        end
        r = '0; r.req = ReqLookup; r.op = 8'd1; r.count = '1;
        send_beat(r);
        drain();

        // Random phases under several seeds, extremes included.
        for (int ph = 0; ph < 5; ph++) begin
            case (ph)
                0: load_seed(32'd1);
                1: load_seed(32'hFFFF_FFFF);
                2: load_seed($urandom() | 32'd1);
                3: load_seed(32'h8000_0000);
                default: load_seed($urandom() | 32'd2);
            endcase
            idle_free = (ph == 2);
            for (int k = 0; k < NumRandom / 5; k++) send_beat(random_request());
            drain();
        end
        idle_free = 1'b0;
        drain();
        repeat (900) @(negedge aclk);

        if (errors == 0 && pending_verdicts.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            if (pending_verdicts.size() != 0)
                $error("%0d results never arrived", pending_verdicts.size());
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
